// ===== rtl/bse_pkg.sv =====
// Package for the bit-vector set engine: sizes, opcodes, sequencer states
// and the word popcount function. No dependencies.
`default_nettype none

package bse_pkg;

    // Sizing of the set store.
    localparam int NUM_SETS      = 4;
    localparam int MAX_ELEMENTS  = 1024;
    localparam int WORD_BITS     = 32;
    localparam int WORDS_PER_SET = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_DEPTH   = NUM_SETS * WORDS_PER_SET;

    // Field and index widths.
    localparam int OP_W       = 3;
    localparam int SET_W      = 2;
    localparam int ELEM_W     = 10;
    localparam int CNT_W      = 11;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = $clog2(WORDS_PER_SET);
    localparam int WCNT_W     = $clog2(WORDS_PER_SET + 1);
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int POP_W      = $clog2(WORD_BITS + 1);

    // Popcount masks, one byte pattern repeated across the word.
    localparam logic [WORD_BITS-1:0] M_PAIRS   = {(WORD_BITS / 8){8'h55}};
    localparam logic [WORD_BITS-1:0] M_NIBBLES = {(WORD_BITS / 8){8'h33}};
    localparam logic [WORD_BITS-1:0] M_BYTES   = {(WORD_BITS / 8){8'h0F}};

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_UNION = 3'd2,
        OP_INTER = 3'd3,
        OP_COUNT = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } t_state;

    // Number of set bits in one word: pairwise, nibble and byte sums, then
    // the bytes are added together.
    function automatic logic [POP_W-1:0] word_popcount(input t_word w);
        t_word            v;
        logic [POP_W-1:0] sum;
        v   = w - ((w >> 1) & M_PAIRS);
        v   = (v & M_NIBBLES) + ((v >> 2) & M_NIBBLES);
        v   = (v + (v >> 4)) & M_BYTES;
        sum = '0;
        for (int i = 0; i < WORD_BITS / 8; i++) begin
            sum = sum + POP_W'(v[8*i +: 8]);
        end
        return sum;
    endfunction

    // True when a set number addresses an existing set.
    function automatic logic set_ok(input logic [SET_W-1:0] s);
        return int'(s) < NUM_SETS;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bitset_set_engine.sv =====
// Bit-vector set engine top level: sequencer, valid bits and result register.
// Depends on bse_pkg and bse_ram.
`default_nettype none

// The engine keeps four sets of up to 1024 elements, each a row of 32 words
// in a two-read, one-write RAM; per-word valid bits make the store read as
// empty right after reset, so there is no clearing pass. One item is taken
// at a time and the input stalls until its result is in the output register.
// Every word is handled by the one RAM port set, one word per cycle: add
// works on one word, clear on every word of the row, union, intersection
// and count on the words in use; an invalid or out-of-range item goes
// straight to the result. A finished result may wait in the output register
// while the next item is accepted. The element_count register has a write
// port that is always ready; the user must write it only while the engine is idle, as the block does not enforce this.
module bitset_set_engine
    import bse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Item input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [SET_W-1:0]  i_dest_set,
    input  wire logic [SET_W-1:0]  i_src_a,
    input  wire logic [SET_W-1:0]  i_src_b,
    input  wire logic [ELEM_W-1:0] i_element,
    // Result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [CNT_W-1:0]  o_member_count,
    output logic                   o_status,
    // Configuration write
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_element_count
);

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op;
    logic [SET_W-1:0]       r_dest, r_a, r_b;
    logic [ELEM_W-1:0]      r_elem;
    logic [WCNT_W-1:0]      r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [WORD_IDX_W-1:0]  r_pend_word, n_pend_word;
    logic                   r_va_ok, r_vb_ok;
    logic                   r_valid [STORE_DEPTH];
    logic [CNT_W-1:0]       r_acc, n_acc;
    logic                   r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    logic [CNT_W-1:0]       r_out_count;
    logic                   r_out_status;
    logic [CNT_W-1:0]       r_elem_count;

    logic                   in_accept;
    logic                   out_load;
    logic                   issue;
    logic                   item_bad;
    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W:0]         used_sum;
    logic [WCNT_W-1:0]      used_words;
    logic [WCNT_W-1:0]      word_limit;
    logic [WORD_IDX_W-1:0]  word_sel;
    logic [SET_W-1:0]       set_a_sel;
    logic [ADDR_W-1:0]      raddr_a, raddr_b, waddr;
    logic                   ram_we;
    t_word                  wdata;
    t_word                  rdata_a, rdata_b;
    t_word                  word_a, word_b;

    // Set store.
    bse_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    // Effective element count and number of words in use.
    always_comb begin
        if (r_elem_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_elem_count > CNT_W'(MAX_ELEMENTS)) begin
            eff_count = CNT_W'(MAX_ELEMENTS);
        end else begin
            eff_count = r_elem_count;
        end
        used_sum   = {1'b0, eff_count} + (CNT_W + 1)'(WORD_BITS - 1);
        used_words = WCNT_W'(used_sum >> BIT_IDX_W);
    end

    // Words visited by the current operation.
    always_comb begin
        case (r_op)
            OP_ADD:   word_limit = WCNT_W'(1);
            OP_CLEAR: word_limit = WCNT_W'(WORDS_PER_SET);
            default:  word_limit = used_words;
        endcase
    end

    // Read addresses: port A reads the first operand or the destination.
    assign word_sel  = (r_op == OP_ADD) ? r_elem[ELEM_W-1:BIT_IDX_W]
                                        : r_idx[WORD_IDX_W-1:0];
    assign set_a_sel = (r_op == OP_UNION || r_op == OP_INTER) ? r_a : r_dest;
    assign raddr_a   = {set_a_sel, word_sel};
    assign raddr_b   = {r_b, r_idx[WORD_IDX_W-1:0]};

    // Words never written read as zero.
    assign word_a = r_va_ok ? rdata_a : '0;
    assign word_b = r_vb_ok ? rdata_b : '0;

    // Input check on the item being offered.
    always_comb begin
        item_bad = (i_opcode > OP_COUNT) || !set_ok(i_dest_set);
        if ((i_opcode == OP_UNION || i_opcode == OP_INTER) &&
            (!set_ok(i_src_a) || !set_ok(i_src_b))) begin
            item_bad = 1'b1;
        end
    end

    assign in_accept = i_in_valid && (r_state == ST_IDLE);

    // Sequencer: next state, RAM controls and result loading.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_word = r_pend_word;
        n_acc       = r_acc;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        out_load    = 1'b0;
        issue       = 1'b0;
        ram_we      = 1'b0;
        waddr       = {r_dest, r_pend_word};
        wdata       = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx    = '0;
                    n_acc    = '0;
                    n_status = 1'b0;
                    if (item_bad) begin
                        n_state = ST_RESULT;
                    end else if (i_opcode == OP_ADD &&
                                 CNT_W'(i_element) >= eff_count) begin
                        n_status = 1'b1;
                        n_state  = ST_RESULT;
                    end else begin
                        n_state = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP: begin
                // Front end: issue one word per cycle.
                if (r_idx < word_limit) begin
                    n_idx = r_idx + WCNT_W'(1);
                    if (r_op == OP_CLEAR) begin
                        ram_we = 1'b1;
                        waddr  = {r_dest, r_idx[WORD_IDX_W-1:0]};
                        wdata  = '0;
                    end else begin
                        issue       = 1'b1;
                        n_pend      = 1'b1;
                        n_pend_word = word_sel;
                    end
                end else begin
                    n_state = ST_RESULT;
                end
                // Back end: combine the word read in the previous cycle.
                if (r_pend) begin
                    case (r_op)
                        OP_ADD: begin
                            ram_we = 1'b1;
                            wdata  = word_a |
                                     (t_word'(1) << r_elem[BIT_IDX_W-1:0]);
                        end
                        OP_UNION: begin
                            ram_we = 1'b1;
                            wdata  = word_a | word_b;
                        end
                        OP_INTER: begin
                            ram_we = 1'b1;
                            wdata  = word_a & word_b;
                        end
                        OP_COUNT: begin
                            n_acc = r_acc + CNT_W'(word_popcount(word_a));
                        end
                        default: begin
                            n_acc = r_acc;
                        end
                    endcase
                end
            end

            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_elem_count <= CNT_W'(MAX_ELEMENTS);
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_elem_count <= i_cfg_element_count;
            end
        end
    end

    // Per-word valid bits: a word reads as zero until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (ram_we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    // Item fields, sweep counters and result payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_opcode;
            r_dest <= i_dest_set;
            r_a    <= i_src_a;
            r_b    <= i_src_b;
            r_elem <= i_element;
        end
        if (issue) begin
            r_va_ok <= r_valid[raddr_a];
            r_vb_ok <= r_valid[raddr_b];
        end
        r_idx       <= n_idx;
        r_pend_word <= n_pend_word;
        r_acc       <= n_acc;
        r_status    <= n_status;
        if (out_load) begin
            r_out_count  <= r_acc;
            r_out_status <= r_status;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_member_count = r_out_count;
    assign o_status       = r_out_status;
    assign o_cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/bse_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire
